@@ rtl/core/amx_inv_pkg.sv @@
// shared constants and types for the affine matrix inverse pipeline
package amx_inv_pkg;

    localparam int LANES  = 6;
    localparam int ENT_W  = 32;
    localparam int DET_W  = 64;
    localparam int NUM_W  = 65;
    localparam int QBITS  = 33;

    localparam logic [QBITS-1:0] POS_MAX = QBITS'(33'h0_7FFF_FFFF);
    localparam logic [QBITS-1:0] NEG_MAX = QBITS'(33'h0_8000_0000);

    typedef logic [ENT_W-1:0] entry_t;
    typedef logic [DET_W-1:0] mag_t;
    typedef logic [QBITS-1:0] quo_t;

endpackage

@@ rtl/core/affine_matrix_inverse.sv @@
// top level: pipelined inverse of a 2x3 affine matrix in signed fixed point
//
// One matrix per transaction on s_axis, one inverse per transaction on m_axis, in order.
// The block takes a new matrix every clock cycle unless m_tready stalls the output; the
// inverse comes from the 33 restoring-division steps, one register stage per quotient bit,
// that run in parallel for the six entries. The six products
// are formed in the first stage, the determinant and translation numerators in the
// second. A stall on m_tready holds the whole pipeline and drops s_tready.
// A zero determinant gives all-zero entries with both flags clear.
module affine_matrix_inverse #(
    parameter int FRAC_BITS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [191:0] s_tdata,   // in_a, in_b, in_c, in_d, in_e, in_f
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [191:0] m_tdata,   // out_a, out_b, out_c, out_d, out_e, out_f
    output logic [1:0]   m_tuser    // invertible, clipped
);
    import amx_inv_pkg::*;

    localparam int NW = DET_W + 2 * FRAC_BITS;

    logic adv;

    // stage 1: products
    logic signed [DET_W-1:0] pad_reg, pcb_reg, pcf_reg, pde_reg, pbe_reg, paf_reg;
    entry_t ea_reg, eb_reg, ec_reg, ed_reg;
    logic v1_reg;

    // stage 2: determinant and numerators
    logic signed [NUM_W-1:0] det_reg;
    logic signed [NUM_W-1:0] num_reg [LANES];
    logic v2_reg;

    // stage 3: magnitudes and signs
    mag_t mag_reg [LANES];
    logic neg_reg [LANES];
    mag_t dv3_reg;
    logic nz3_reg, v3_reg;

    // division stages 0..QBITS
    mag_t r_reg    [0:QBITS][LANES];
    mag_t r_next   [0:QBITS][LANES];
    quo_t q_reg    [0:QBITS][LANES];
    quo_t q_next   [0:QBITS][LANES];
    quo_t lo_reg   [0:QBITS][LANES];
    quo_t lo_next  [0:QBITS][LANES];
    logic big_reg  [0:QBITS][LANES];
    logic big_next [0:QBITS][LANES];
    logic sg_reg   [0:QBITS][LANES];
    logic sg_next  [0:QBITS][LANES];
    mag_t dv_reg   [0:QBITS];
    mag_t dv_next  [0:QBITS];
    logic nz_reg   [0:QBITS];
    logic nz_next  [0:QBITS];
    logic v_reg    [0:QBITS];
    logic v_next   [0:QBITS];

    logic [191:0] m_tdata_reg, m_tdata_next;
    logic [1:0]   m_tuser_reg, m_tuser_next;
    logic         m_tvalid_reg;

    function automatic mag_t mag_of(input logic signed [NUM_W-1:0] x);
        logic [NUM_W-1:0] t;
        t = x[NUM_W-1] ? NUM_W'(-x) : NUM_W'(x);
        return t[DET_W-1:0];
    endfunction

    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            pad_reg <= $signed(s_tdata[31:0])    * $signed(s_tdata[127:96]);
            pcb_reg <= $signed(s_tdata[95:64])   * $signed(s_tdata[63:32]);
            pcf_reg <= $signed(s_tdata[95:64])   * $signed(s_tdata[191:160]);
            pde_reg <= $signed(s_tdata[127:96])  * $signed(s_tdata[159:128]);
            pbe_reg <= $signed(s_tdata[63:32])   * $signed(s_tdata[159:128]);
            paf_reg <= $signed(s_tdata[31:0])    * $signed(s_tdata[191:160]);
            ea_reg  <= s_tdata[31:0];
            eb_reg  <= s_tdata[63:32];
            ec_reg  <= s_tdata[95:64];
            ed_reg  <= s_tdata[127:96];

            det_reg    <= NUM_W'(pad_reg) - NUM_W'(pcb_reg);
            num_reg[0] <= NUM_W'($signed(ed_reg));
            num_reg[1] <= -NUM_W'($signed(eb_reg));
            num_reg[2] <= -NUM_W'($signed(ec_reg));
            num_reg[3] <= NUM_W'($signed(ea_reg));
            num_reg[4] <= NUM_W'(pcf_reg) - NUM_W'(pde_reg);
            num_reg[5] <= NUM_W'(pbe_reg) - NUM_W'(paf_reg);

            for (int l = 0; l < LANES; l++) begin
                mag_reg[l] <= mag_of(num_reg[l]);
                neg_reg[l] <= num_reg[l][NUM_W-1] ^ det_reg[NUM_W-1];
            end
            dv3_reg <= mag_of(det_reg);
            nz3_reg <= (det_reg != '0);

            for (int k = 0; k <= QBITS; k++) begin
                dv_reg[k] <= dv_next[k];
                nz_reg[k] <= nz_next[k];
                for (int l = 0; l < LANES; l++) begin
                    r_reg[k][l]   <= r_next[k][l];
                    q_reg[k][l]   <= q_next[k][l];
                    lo_reg[k][l]  <= lo_next[k][l];
                    big_reg[k][l] <= big_next[k][l];
                    sg_reg[k][l]  <= sg_next[k][l];
                end
            end
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= m_tuser_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
            for (int k = 0; k <= QBITS; k++) begin
                v_reg[k] <= 1'b0;
            end
        end else if (adv) begin
            v1_reg       <= s_tvalid;
            v2_reg       <= v1_reg;
            v3_reg       <= v2_reg;
            m_tvalid_reg <= v_reg[QBITS];
            for (int k = 0; k <= QBITS; k++) begin
                v_reg[k] <= v_next[k];
            end
        end
    end

    // overflow precheck, then one quotient bit per stage
    always_comb begin
        logic [NW-1:0] n;
        logic [DET_W:0] r2;
        dv_next[0] = dv3_reg;
        nz_next[0] = nz3_reg;
        v_next[0]  = v3_reg;
        for (int l = 0; l < LANES; l++) begin
            n = (l < 4) ? (NW'(mag_reg[l]) << (2 * FRAC_BITS))
                        : (NW'(mag_reg[l]) << FRAC_BITS);
            big_next[0][l] = (NW'(n >> QBITS) >= NW'(dv3_reg));
            r_next[0][l]   = big_next[0][l] ? '0 : DET_W'(n >> QBITS);
            q_next[0][l]   = '0;
            lo_next[0][l]  = n[QBITS-1:0];
            sg_next[0][l]  = neg_reg[l];
        end
        for (int k = 1; k <= QBITS; k++) begin
            dv_next[k] = dv_reg[k-1];
            nz_next[k] = nz_reg[k-1];
            v_next[k]  = v_reg[k-1];
            for (int l = 0; l < LANES; l++) begin
                r2 = {r_reg[k-1][l], lo_reg[k-1][l][QBITS-1]};
                if (r2 >= {1'b0, dv_reg[k-1]}) begin
                    r_next[k][l] = DET_W'(r2 - {1'b0, dv_reg[k-1]});
                    q_next[k][l] = {q_reg[k-1][l][QBITS-2:0], 1'b1};
                end else begin
                    r_next[k][l] = r2[DET_W-1:0];
                    q_next[k][l] = {q_reg[k-1][l][QBITS-2:0], 1'b0};
                end
                lo_next[k][l]  = {lo_reg[k-1][l][QBITS-2:0], 1'b0};
                big_next[k][l] = big_reg[k-1][l];
                sg_next[k][l]  = sg_reg[k-1][l];
            end
        end
    end

    // sign, saturation and singular masking
    always_comb begin
        quo_t   q;
        entry_t e;
        logic   clip;
        clip = 1'b0;
        m_tdata_next = '0;
        for (int l = 0; l < LANES; l++) begin
            q = q_reg[QBITS][l];
            if (sg_reg[QBITS][l]) begin
                if (big_reg[QBITS][l] || q > NEG_MAX) begin
                    clip = 1'b1;
                    q = NEG_MAX;
                end
                e = ENT_W'(-q);
            end else begin
                if (big_reg[QBITS][l] || q > POS_MAX) begin
                    clip = 1'b1;
                    q = POS_MAX;
                end
                e = q[ENT_W-1:0];
            end
            m_tdata_next[l*ENT_W +: ENT_W] = nz_reg[QBITS] ? e : '0;
        end
        m_tuser_next = {clip && nz_reg[QBITS], nz_reg[QBITS]};
    end

    a_singular_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata == '0 && !m_tuser[1])
        else $error("singular result carries nonzero data");

    a_enter: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> v1_reg)
        else $error("accepted transaction lost at first stage");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(v_reg[QBITS]) && $stable(v3_reg))
        else $error("pipeline moved during stall");

endmodule

@@ tb/sv/amx_inv_checker.sv @@
// checker for the affine matrix inverse: predicts each inverse and compares results
module amx_inv_checker #(
    parameter int FRAC_BITS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [191:0] s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [191:0] m_tdata,
    input  logic [1:0]   m_tuser,
    output int           errors,
    output int           pending,
    output int           checked,
    output int           singular_seen,
    output int           clipped_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    import amx_inv_pkg::*;

    typedef struct packed {
        logic [191:0] entries;
        logic [1:0]   flags;
    } inverse_t;

    inverse_t inverse_q[$];

    function automatic entry_t quotient_sat(input logic signed [63:0] num, input int sh,
                                            input logic signed [63:0] den, ref bit clip);
        logic signed [127:0] wide;
        logic signed [127:0] den_w;
        logic signed [127:0] q;
        wide = num;
        wide = wide <<< sh;
        den_w = den;
        q = wide / den_w;
        if (q > 128'sd2147483647) begin
            clip = 1;
            return 32'h7FFF_FFFF;
        end
        if (q < -128'sd2147483648) begin
            clip = 1;
            return 32'h8000_0000;
        end
        return q[31:0];
    endfunction

    function automatic inverse_t invert_matrix(input logic [191:0] m);
        logic signed [63:0] a, b, c, d, e, f, det;
        entry_t oa, ob, oc, od, oe, of;
        bit clip;
        inverse_t r;
        a = $signed(m[31:0]);
        b = $signed(m[63:32]);
        c = $signed(m[95:64]);
        d = $signed(m[127:96]);
        e = $signed(m[159:128]);
        f = $signed(m[191:160]);
        det = a * d - c * b;
        clip = 0;
        if (det == 0) begin
            r.entries = '0;
            r.flags = 2'b00;
            return r;
        end
        oa = quotient_sat(d, 2 * FRAC_BITS, det, clip);
        ob = quotient_sat(-b, 2 * FRAC_BITS, det, clip);
        oc = quotient_sat(-c, 2 * FRAC_BITS, det, clip);
        od = quotient_sat(a, 2 * FRAC_BITS, det, clip);
        oe = quotient_sat(c * f - d * e, FRAC_BITS, det, clip);
        of = quotient_sat(b * e - a * f, FRAC_BITS, det, clip);
        r.entries = {of, oe, od, oc, ob, oa};
        r.flags = {clip, 1'b1};
        return r;
    endfunction

    assign pending = inverse_q.size();

    initial begin
        errors = 0;
        checked = 0;
        singular_seen = 0;
        clipped_seen = 0;
    end

    always @(posedge aclk) begin
        inverse_t want;
        if (aresetn && s_tvalid && s_tready)
            inverse_q.push_back(invert_matrix(s_tdata));
        if (aresetn && m_tvalid && m_tready) begin
            if (inverse_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result data=%h user=%b", $time, m_tdata, m_tuser);
            end else begin
                want = inverse_q.pop_front();
                checked++;
                if (!m_tuser[0]) singular_seen++;
                if (m_tuser[1]) clipped_seen++;
                for (int k = 0; k < LANES; k++) begin
                    if (m_tdata[k*ENT_W +: ENT_W] !== want.entries[k*ENT_W +: ENT_W]) begin
                        errors++;
                        $display("%0t: entry %0d expected %h actual %h", $time, k,
                                 want.entries[k*ENT_W +: ENT_W], m_tdata[k*ENT_W +: ENT_W]);
                    end
                end
                if (m_tuser[0] !== want.flags[0]) begin
                    errors++;
                    $display("%0t: invertible expected %b actual %b", $time,
                             want.flags[0], m_tuser[0]);
                end
                if (m_tuser[1] !== want.flags[1]) begin
                    errors++;
                    $display("%0t: clipped expected %b actual %b", $time,
                             want.flags[1], m_tuser[1]);
                end
            end
        end
    end
endmodule

@@ tb/sv/tb_affine_matrix_inverse.sv @@
// testbench top for the affine matrix inverse: stimulus, flow control and verdict
module tb_affine_matrix_inverse;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_RANDOM = 1800;
    localparam int CYCLE_LIMIT = 400000;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [191:0] s_tdata;    // in_a, in_b, in_c, in_d, in_e, in_f
    logic         m_tvalid;
    logic         m_tready;
    logic [191:0] m_tdata;    // out_a, out_b, out_c, out_d, out_e, out_f
    logic [1:0]   m_tuser;    // invertible, clipped

    int errors, pending, checked, singular_seen, clipped_seen;
    int sent;
    int cycles;
    bit long_hold_done;

    affine_matrix_inverse DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    amx_inv_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .errors(errors), .pending(pending), .checked(checked),
        .singular_seen(singular_seen), .clipped_seen(clipped_seen)
    );

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("timeout after %0d cycles", cycles);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    function automatic logic [31:0] pick_entry(input int mode);
        case (mode)
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
            2: begin
                case ($urandom_range(0, 7))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'h0000_0000;
                    3: return 32'h0000_0001;
                    4: return 32'hFFFF_FFFF;
                    5: return 32'h0001_0000;
                    6: return 32'hFFFF_0000;
                    default: return $urandom;
                endcase
            end
            default: return 32'($signed($urandom_range(0, 1 << 17)) - (1 << 16) + 32'sh0001_0000);
        endcase
    endfunction

    function automatic logic [191:0] random_matrix();
        logic [31:0] a, b, c, d, e, f;
        int kind;
        kind = $urandom_range(0, 19);
        e = pick_entry($urandom_range(0, 2));
        f = pick_entry($urandom_range(0, 2));
        if (kind < 9) begin
            a = pick_entry(3); d = pick_entry(3); b = pick_entry(1); c = pick_entry(1);
        end else if (kind < 13) begin
            a = pick_entry(0); b = pick_entry(0); c = pick_entry(0); d = pick_entry(0);
        end else if (kind < 16) begin
            a = pick_entry($urandom_range(0, 2)); b = pick_entry($urandom_range(0, 2));
            if ($urandom_range(0, 1)) begin
                c = a; d = b;
            end else begin
                c = pick_entry(0); d = pick_entry(0); a = 0; b = 0;
            end
        end else begin
            a = pick_entry(2); b = pick_entry(2); c = pick_entry(2); d = pick_entry(2);
        end
        return {f, e, d, c, b, a};
    endfunction

    task automatic send_matrix(input logic [191:0] m);
        bit ok;
        s_tdata <= m;
        s_tvalid <= 1'b1;
        do begin
            @(negedge aclk);
            ok = s_tready;
            @(posedge aclk);
        end while (!ok);
        sent++;
    endtask

    task automatic maybe_gap(ref int burst_left);
        int g;
        if (burst_left > 0) begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(0, 30);
        g = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
    endtask

    initial begin
        logic [191:0] directed[$];
        int burst_left;
        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        sent = 0;
        burst_left = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        directed.push_back({32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h0, 32'h0001_0000});
        directed.push_back('0);
        directed.push_back({6{32'h7FFF_FFFF}});
        directed.push_back({6{32'h8000_0000}});
        directed.push_back({6{32'hFFFF_FFFF}});
        directed.push_back({32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                            32'h8000_0000, 32'h8000_0000});
        directed.push_back({32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h0,
                            32'h0, 32'h8000_0000});
        directed.push_back({32'h0003_0000, 32'hFFFE_0000, 32'h0002_0000, 32'h0,
                            32'h0, 32'h0002_0000});
        directed.push_back({32'h0, 32'h0, 32'h1, 32'h0, 32'h0, 32'h1});
        directed.push_back({32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 32'h0, 32'h0, 32'h1});
        directed.push_back({32'h0, 32'h0, 32'h0002_0000, 32'h0002_0000, 32'h0001_0000,
                            32'h0001_0000});
        directed.push_back({32'h1234_5678, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0});
        directed.push_back({32'h0, 32'h0, 32'hFFFF_0000, 32'h0, 32'h0, 32'hFFFF_0000});
        directed.push_back({32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'hFFFF_0000, 32'h0});
        directed.push_back({32'h0010_0000, 32'hFFF0_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                            32'h7FFF_FFFF, 32'h7FFF_FFFF});
        directed.push_back({32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_8000, 32'h0,
                            32'h0, 32'h0000_8000});
        directed.push_back({32'hAAAA_AAAA, 32'h5555_5555, 32'h0100_0000, 32'h0,
                            32'h0, 32'h0000_0100});
        directed.push_back({32'h0, 32'h0, 32'h8000_0000, 32'h0, 32'h0, 32'h8000_0000});

        foreach (directed[i]) begin
            maybe_gap(burst_left);
            send_matrix(directed[i]);
        end
        repeat (N_RANDOM) begin
            maybe_gap(burst_left);
            send_matrix(random_matrix());
        end
        s_tvalid <= 1'b0;

        while (pending != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);

        $display("sent %0d matrices, checked %0d inverses", sent, checked);
        $display("singular results %0d, saturated results %0d", singular_seen, clipped_seen);
        if (errors == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        int mode, n;
        m_tready <= 1'b0;
        long_hold_done = 0;
        @(posedge aclk iff aresetn);
        forever begin
            if (!long_hold_done && checked > 400) begin
                @(posedge aclk);
                m_tready <= 1'b0;
                repeat (300) @(posedge aclk);
                long_hold_done = 1;
            end else begin
                mode = $urandom_range(0, 3);
                n = $urandom_range(1, 40);
                repeat (n) begin
                    @(posedge aclk);
                    case (mode)
                        0: m_tready <= 1'b1;
                        1: m_tready <= 1'($urandom_range(0, 1));
                        2: m_tready <= ($urandom_range(0, 3) != 0);
                        default: m_tready <= ($urandom_range(0, 4) == 0);
                    endcase
                end
            end
        end
    end
endmodule

@@ affine_matrix_inverse.f @@
rtl/core/amx_inv_pkg.sv
rtl/core/affine_matrix_inverse.sv
tb/sv/amx_inv_checker.sv
tb/sv/tb_affine_matrix_inverse.sv
